// ----- hw/rtl/ssud_pkg.sv -----
`default_nettype none

package ssud_pkg;

  localparam int unsigned ElemW = 32;
  localparam int unsigned CntW = 6;
  localparam int unsigned IdxW = 5;
  localparam int unsigned MaxSetDepth = 32;
  localparam int unsigned DefSetDepth = 32;
  localparam int unsigned CmdFifoDepth = 2;
  localparam int unsigned OutFifoDepth = 2;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  typedef enum logic [0:0] {
    RegOperation = 1'b0
  } reg_index_e;

  typedef enum logic [0:0] {
    OpUnion = 1'b0,
    OpDiff  = 1'b1
  } op_e;

  typedef struct packed {
    logic             set_select;
    logic [ElemW-1:0] element;
    logic             has_element;
    logic             last_of_set;
  } item_t;

  typedef struct packed {
    logic [ElemW-1:0] result_element;
    logic             result_empty;
    logic             last;
    logic             load_error;
  } result_t;

  typedef struct packed {
    logic             wr_en;
    logic             wr_sel;
    logic [IdxW-1:0]  wr_idx;
    logic [ElemW-1:0] wr_data;
    logic             merge;
    logic [CntW-1:0]  cnt_a;
    logic [CntW-1:0]  cnt_b;
    logic             err;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ssud_fifo.sv -----
`default_nettype none

module ssud_fifo #(
  parameter type T = logic,
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire T     data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          data_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  T                 mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == FillW'(Depth));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + FillW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ssud_front.sv -----
`default_nettype none

module ssud_front #(
  parameter int unsigned SET_DEPTH = ssud_pkg::DefSetDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ssud_pkg::item_t item_i,
  output logic                full_o,
  output logic                cmd_push_o,
  output ssud_pkg::cmd_t      cmd_o,
  input  wire logic           cmd_full_i
);

  logic [ssud_pkg::CntW-1:0]  cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [ssud_pkg::ElemW-1:0] last_a_q, last_a_d, last_b_q, last_b_d;
  logic                       err_q, err_d;
  logic                       accept, is_b, bad, wr, err_now, trig;
  logic [ssud_pkg::CntW-1:0]  cnt_sel;
  logic [ssud_pkg::ElemW-1:0] last_sel;

  assign full_o   = cmd_full_i;
  assign accept   = push_i && !cmd_full_i;
  assign is_b     = item_i.set_select;
  assign cnt_sel  = is_b ? cnt_b_q : cnt_a_q;
  assign last_sel = is_b ? last_b_q : last_a_q;
  assign bad      = (cnt_sel >= ssud_pkg::CntW'(SET_DEPTH))
                 || ((cnt_sel != '0) && (item_i.element <= last_sel));
  assign wr       = item_i.has_element && !bad;
  assign err_now  = err_q || (item_i.has_element && bad);
  assign trig     = item_i.set_select && item_i.last_of_set;

  always_comb begin
    cmd_o.wr_en   = wr;
    cmd_o.wr_sel  = is_b;
    cmd_o.wr_idx  = cnt_sel[ssud_pkg::IdxW-1:0];
    cmd_o.wr_data = item_i.element;
    cmd_o.merge   = trig;
    cmd_o.cnt_a   = cnt_a_q + ssud_pkg::CntW'(wr && !is_b);
    cmd_o.cnt_b   = cnt_b_q + ssud_pkg::CntW'(wr && is_b);
    cmd_o.err     = err_now;
    cmd_push_o    = accept && (wr || trig);

    cnt_a_d  = cnt_a_q;
    cnt_b_d  = cnt_b_q;
    last_a_d = last_a_q;
    last_b_d = last_b_q;
    err_d    = err_q;
    if (accept) begin
      if (trig) begin
        cnt_a_d = '0;
        cnt_b_d = '0;
        err_d   = 1'b0;
      end else begin
        cnt_a_d = cmd_o.cnt_a;
        cnt_b_d = cmd_o.cnt_b;
        err_d   = err_now;
        if (wr && !is_b) begin
          last_a_d = item_i.element;
        end
        if (wr && is_b) begin
          last_b_d = item_i.element;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      err_q   <= 1'b0;
    end else begin
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_a_q <= last_a_d;
    last_b_q <= last_b_d;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ssud_back.sv -----
`default_nettype none

module ssud_back #(
  parameter int unsigned SET_DEPTH = ssud_pkg::DefSetDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  wire ssud_pkg::cmd_t  cmd_i,
  output logic                 cmd_pop_o,
  input  wire ssud_pkg::op_e   op_i,
  input  wire logic            out_full_i,
  output logic                 out_push_o,
  output ssud_pkg::result_t    out_o
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StFetch = 4'b0010,
    StStep  = 4'b0100,
    StFlush = 4'b1000
  } state_e;

  state_e                     state_q, state_d;
  logic [ssud_pkg::ElemW-1:0] mem_a [SET_DEPTH];
  logic [ssud_pkg::ElemW-1:0] mem_b [SET_DEPTH];
  logic [ssud_pkg::ElemW-1:0] ra_q, rb_q;
  logic [ssud_pkg::CntW-1:0]  ia_q, ia_d, ib_q, ib_d, cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic                       err_q, err_d, pend_valid_q, pend_valid_d;
  logic [ssud_pkg::ElemW-1:0] pend_q, pend_d;
  ssud_pkg::op_e              op_q, op_d;
  logic                       has_a, has_b, cont, emit, inc_a, inc_b;
  logic [ssud_pkg::ElemW-1:0] emit_val;

  assign has_a = ia_q < cnt_a_q;
  assign has_b = ib_q < cnt_b_q;
  assign cont  = has_a || ((op_q == ssud_pkg::OpUnion) && has_b);

  always_comb begin
    emit     = 1'b0;
    emit_val = ra_q;
    inc_a    = 1'b0;
    inc_b    = 1'b0;
    if (op_q == ssud_pkg::OpUnion) begin
      emit = 1'b1;
      if (has_a && has_b && (ra_q == rb_q)) begin
        inc_a = 1'b1;
        inc_b = 1'b1;
      end else if (has_a && (!has_b || (ra_q < rb_q))) begin
        inc_a = 1'b1;
      end else begin
        emit_val = rb_q;
        inc_b    = 1'b1;
      end
    end else begin
      if (!has_b || (ra_q < rb_q)) begin
        emit  = 1'b1;
        inc_a = 1'b1;
      end else if (ra_q == rb_q) begin
        inc_a = 1'b1;
        inc_b = 1'b1;
      end else begin
        inc_b = 1'b1;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    ia_d         = ia_q;
    ib_d         = ib_q;
    cnt_a_d      = cnt_a_q;
    cnt_b_d      = cnt_b_q;
    err_d        = err_q;
    op_d         = op_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    cmd_pop_o    = 1'b0;
    out_push_o   = 1'b0;
    out_o        = '0;
    case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.merge) begin
            cnt_a_d      = cmd_i.cnt_a;
            cnt_b_d      = cmd_i.cnt_b;
            err_d        = cmd_i.err;
            op_d         = op_i;
            ia_d         = '0;
            ib_d         = '0;
            pend_valid_d = 1'b0;
            state_d      = StFetch;
          end
        end
      end
      StFetch: begin
        state_d = StStep;
      end
      StStep: begin
        if (!cont) begin
          state_d = StFlush;
        end else if (!(emit && pend_valid_q && out_full_i)) begin
          if (emit && pend_valid_q) begin
            out_push_o           = 1'b1;
            out_o.result_element = pend_q;
            out_o.load_error     = err_q;
          end
          if (emit) begin
            pend_valid_d = 1'b1;
            pend_d       = emit_val;
          end
          ia_d    = ia_q + ssud_pkg::CntW'(inc_a);
          ib_d    = ib_q + ssud_pkg::CntW'(inc_b);
          state_d = StFetch;
        end
      end
      StFlush: begin
        if (!out_full_i) begin
          out_push_o           = 1'b1;
          out_o.result_element = pend_valid_q ? pend_q : '0;
          out_o.result_empty   = !pend_valid_q;
          out_o.last           = 1'b1;
          out_o.load_error     = err_q;
          state_d              = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      ia_q         <= '0;
      ib_q         <= '0;
      cnt_a_q      <= '0;
      cnt_b_q      <= '0;
      err_q        <= 1'b0;
      op_q         <= ssud_pkg::OpUnion;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      ia_q         <= ia_d;
      ib_q         <= ib_d;
      cnt_a_q      <= cnt_a_d;
      cnt_b_q      <= cnt_b_d;
      err_q        <= err_d;
      op_q         <= op_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if ((state_q == StIdle) && cmd_valid_i && cmd_i.wr_en) begin
      if (cmd_i.wr_sel) begin
        mem_b[cmd_i.wr_idx] <= cmd_i.wr_data;
      end else begin
        mem_a[cmd_i.wr_idx] <= cmd_i.wr_data;
      end
    end
    ra_q <= mem_a[ia_q[ssud_pkg::IdxW-1:0]];
    rb_q <= mem_b[ib_q[ssud_pkg::IdxW-1:0]];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_set_union_difference_core.sv -----
// Sorted set union and difference engine.
// Input items are pushed with push while full is low, one transaction per
// cycle: first the elements of set A, then those of set B, each strictly
// ascending. A transaction with set_select high and last_of_set high ends
// set B and starts the merge of both stored sets.
// Results appear at the head of an output queue: while empty is low the
// oldest result is on result_o, and pop takes it. The final result of an
// operation carries last; an empty result gives a single transaction with
// result_empty set. load_error repeats on every result of the operation.
// A merge step is a registered read of both set memories, then one
// compare; each step emits at most one result, up to 2*SET_DEPTH results
// in all. A two-entry command queue sits between the loader and the merge,
// so the next operation can begin loading while a merge runs; full rises
// only when that queue fills. When pop stays low the output queue fills
// and the merge holds its place. Reset clears counts, error flags, queues
// and the operation register (union); set memories keep their contents.
// The user must write operation over the APB port at address 0 only while
// the block is idle; the block itself does not enforce it.
`default_nettype none

module sorted_set_union_difference_core #(
  parameter int unsigned SET_DEPTH = ssud_pkg::DefSetDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  input  wire ssud_pkg::item_t               item_i,
  output logic                               full,
  output logic                               empty,
  input  wire logic                          pop,
  output ssud_pkg::result_t                  result_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ssud_pkg::PaddrW-1:0]   paddr,
  input  wire logic [ssud_pkg::PdataW-1:0]   pwdata,
  output logic [ssud_pkg::PdataW-1:0]        prdata,
  output logic                               pready
);

  ssud_pkg::op_e     op_q;
  ssud_pkg::cmd_t    front_cmd, back_cmd;
  logic              cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic              out_push, out_full;
  ssud_pkg::result_t out_data;
  logic              reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (ssud_pkg::reg_index_e'(paddr[2]) == ssud_pkg::RegOperation);
  assign prdata  = reg_hit ? ssud_pkg::PdataW'(op_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= ssud_pkg::OpUnion;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      op_q <= ssud_pkg::op_e'(pwdata[0]);
    end
  end

  ssud_front #(
    .SET_DEPTH (SET_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (front_cmd),
    .cmd_full_i (cmd_full)
  );

  ssud_fifo #(
    .T     (ssud_pkg::cmd_t),
    .Depth (ssud_pkg::CmdFifoDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  ssud_back #(
    .SET_DEPTH (SET_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .op_i        (op_q),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_o       (out_data)
  );

  ssud_fifo #(
    .T     (ssud_pkg::result_t),
    .Depth (ssud_pkg::OutFifoDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_data),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ssud_checker.sv -----
`default_nettype none

module ssud_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              empty,
  input wire logic              pop,
  input wire ssud_pkg::result_t result_o,
  input wire logic              pready
);

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.result_empty) |-> result_o.last)
    else $error("Empty result transaction without last.");

  a_empty_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.result_empty) |-> (result_o.result_element == '0))
    else $error("Empty result transaction carries a nonzero element.");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("Waiting result changed before it was popped.");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped.");

endmodule

bind sorted_set_union_difference_core ssud_checker u_ssud_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o),
  .pready   (pready)
);

`default_nettype wire
